@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the sequencer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked including during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/mpts_pkg.sv @@
`timescale 1ns / 1ps
package mpts_pkg;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_CANCEL = 2'd1,
    FUNC_PAGE   = 2'd2,
    FUNC_RESP   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_QUERY = 3'd0,
    KIND_WRITE = 3'd1,
    KIND_READ  = 3'd2,
    KIND_ERROR = 3'd3,
    KIND_DONE  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    WAIT_NONE  = 2'd0,
    WAIT_PAGE  = 2'd1,
    WAIT_WRITE = 2'd2,
    WAIT_READ  = 2'd3
  } await_t;

  typedef enum logic [1:0] {
    MODE_QUICK = 2'd0,
    MODE_FULL  = 2'd1,
    MODE_BASIC = 2'd2,
    MODE_ALT   = 2'd3
  } mode_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WSTART = 2'd1;
  localparam logic [1:0] REG_WEND   = 2'd2;

  localparam logic [3:0] PH_WALK  = 4'd8;
  localparam logic [3:0] PH_AWR   = 4'd9;
  localparam logic [3:0] PH_ARD   = 4'd10;
  localparam logic [3:0] PH_FULLN = 4'd11;
  localparam logic [3:0] PH_SHORT = 4'd2;

  // One classified input transfer handed from the front to the back.
  typedef struct packed {
    func_t       func;
    logic        page_used;
    logic [63:0] read_data;
  } item_t;

  // One result item.
  typedef struct packed {
    kind_t       kind;
    logic [47:0] address;
    logic [63:0] data;
    logic [63:0] actual;
    logic [31:0] error_total;
    logic        last;
  } res_t;

  function automatic logic [63:0] full_pattern(input logic [2:0] idx);
    logic [63:0] p;
    case (idx)
      3'd0: p = 64'h0000000000000000;
      3'd1: p = 64'hFFFFFFFFFFFFFFFF;
      3'd2: p = 64'h5555555555555555;
      3'd3: p = 64'hAAAAAAAAAAAAAAAA;
      3'd4: p = 64'h0123456789ABCDEF;
      3'd5: p = 64'hDEADBEEFCAFEBABE;
      3'd6: p = 64'h0000000000000001;
      3'd7: p = 64'h8000000000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

@@ hdl/memory_pattern_test_sequencer_unit.sv @@
`timescale 1ns / 1ps
// Memory pattern self-test sequencer. Start, cancel, page status answers and memory
// responses enter on the input channel; query, write, read, error and done items leave
// on the output channel, at most two per input, the final one marked by last. An input
// transfer goes into a two-entry queue and is processed once the result buffer has room:
// an input causing one result is taken every cycle while results drain, and one causing
// two fills the two-slot result buffer, so the next input waits until a result leaves.
module memory_pattern_test_sequencer_unit
  import mpts_pkg::*;
#(
  parameter int PAGE_BYTES = 4096,
  parameter int MAX_LOGGED_ERRORS = 64,
  parameter int ADDR_BITS = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [35:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic        page_used,
  input  logic [63:0] read_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [47:0] address,
  output logic [63:0] data,
  output logic [63:0] actual,
  output logic [31:0] error_total,
  output logic        last
);
  logic [1:0]  test_mode;
  logic [35:0] window_start_page, window_end_page;
  logic        q_valid, q_take;
  item_t       q_item;
  res_t        res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      test_mode <= '0;
      window_start_page <= '0;
      window_end_page <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE: test_mode <= cfg_data[1:0];
        REG_WSTART: window_start_page <= cfg_data;
        REG_WEND: window_end_page <= cfg_data;
        default: ;
      endcase
    end
  end

  mpts_front u_front (
    .clk, .rst, .in_valid, .in_func(func), .in_page_used(page_used),
    .in_read_data(read_data), .in_stall, .q_valid, .q_item, .q_take
  );

  mpts_back #(
    .PAGE_BYTES(PAGE_BYTES), .MAX_LOGGED_ERRORS(MAX_LOGGED_ERRORS), .ADDR_BITS(ADDR_BITS)
  ) u_back (
    .clk, .rst, .test_mode, .window_start_page, .window_end_page,
    .q_valid, .q_item, .q_take, .out_valid, .out_res(res), .out_stall
  );

  assign kind = res.kind;
  assign address = res.address;
  assign data = res.data;
  assign actual = res.actual;
  assign error_total = res.error_total;
  assign last = res.last;
endmodule

@@ hdl/mpts_front.sv @@
`timescale 1ns / 1ps
// Input stage: registers transfers into a two-entry queue toward the back end.
module mpts_front
  import mpts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [1:0]  in_func,
  input  logic        in_page_used,
  input  logic [63:0] in_read_data,
  output logic        in_stall,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_take
);
  `include "assert_macros.svh"

  item_t     mem [2];
  logic      wr_ptr;
  logic      rd_ptr;
  logic [1:0] count;
  logic      push;
  logic      pop;

  assign in_stall = (count == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_take;
  assign q_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{func: func_t'(in_func), page_used: in_page_used,
                       read_data: in_read_data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `ASSERT_CLK(a_no_overflow, clk, rst, count <= 2'd2, "queue count out of range")
  `ASSERT_CLK(a_ptr_match, clk, rst, (count == 2'd1) == (wr_ptr != rd_ptr), "queue pointers disagree")
endmodule

@@ hdl/mpts_back.sv @@
`timescale 1ns / 1ps
// Sequencer: one transfer per cycle while results drain, two results max, two-deep buffer.
module mpts_back
  import mpts_pkg::*;
#(
  parameter int PAGE_BYTES = 4096,
  parameter int MAX_LOGGED_ERRORS = 64,
  parameter int ADDR_BITS = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  test_mode,
  input  logic [35:0] window_start_page,
  input  logic [35:0] window_end_page,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_take,
  output logic        out_valid,
  output res_t        out_res,
  input  logic        out_stall
);
  `include "assert_macros.svh"

  localparam int WORDS = PAGE_BYTES / 8;
  localparam int WI_W = $clog2(WORDS + 1);
  localparam int PB_SH = $clog2(PAGE_BYTES);

  logic            run_active, cancel_flag;
  logic [35:0]     cursor_page;
  logic [3:0]      test_phase;
  logic [5:0]      walk_bit;
  logic [WI_W-1:0] word_index;
  logic [31:0]     error_counter;
  await_t          awaiting_kind;

  logic            run_active_next, cancel_flag_next;
  logic [35:0]     cursor_page_next;
  logic [3:0]      test_phase_next;
  logic [5:0]      walk_bit_next;
  logic [WI_W-1:0] word_index_next;
  logic [31:0]     error_counter_next;
  await_t          awaiting_kind_next;

  // Result buffer: two slots, read in order.
  res_t       rb [2];
  logic       rb_rd;
  logic [1:0] rb_cnt;

  res_t r0, r1;
  logic e0, e1;
  logic fire;
  logic [1:0] nres;

  assign q_take = q_valid && (rb_cnt == 2'd0 || (rb_cnt == 2'd1 && !out_stall));
  assign fire = q_valid && q_take;
  assign out_valid = (rb_cnt != 2'd0);
  assign out_res = rb[rb_rd];

  function automatic logic [63:0] mk_addr(input logic [35:0] pg,
                                          input logic [WI_W-1:0] wi);
    logic [63:0] a;
    logic [63:0] m;
    a = ({28'd0, pg} << PB_SH) + ({{(64-WI_W){1'b0}}, wi} << 3);
    m = (ADDR_BITS >= 64) ? '1 : ((64'd1 << ADDR_BITS) - 64'd1);
    return a & m;
  endfunction

  logic        full_m;
  logic [3:0]  ph_count;
  logic [63:0] cur_waddr, cur_paddr, cur_pat;
  logic [63:0] start_paddr;
  logic        mismatch;

  assign full_m = (test_mode == MODE_FULL);
  assign ph_count = full_m ? PH_FULLN : PH_SHORT;
  assign cur_waddr = mk_addr(cursor_page, word_index);
  assign cur_paddr = mk_addr(cursor_page, '0);
  assign start_paddr = mk_addr(window_start_page, '0);

  always_comb begin
    if (full_m) begin
      if (test_phase < PH_WALK) cur_pat = full_pattern(test_phase[2:0]);
      else if (test_phase == PH_WALK) cur_pat = 64'd1 << walk_bit;
      else cur_pat = cur_waddr;
    end else if (test_mode == MODE_BASIC) begin
      cur_pat = (test_phase == 4'd0) ? 64'h0 : 64'hFFFFFFFFFFFFFFFF;
    end else begin
      cur_pat = (test_phase == 4'd0) ? 64'h5555555555555555 : 64'hAAAAAAAAAAAAAAAA;
    end
  end

  assign mismatch = (q_item.read_data != cur_pat);

  // Derived "next position" values used by advance.
  logic [WI_W-1:0] adv_wi;
  logic [3:0]      adv_ph;
  logic [5:0]      adv_wb;
  logic [WI_W:0]   wi_inc;

  always_comb begin
    wi_inc = {1'b0, word_index} + 1'b1;
    adv_wi = wi_inc[WI_W-1:0];
    adv_ph = test_phase;
    adv_wb = walk_bit;
    if (wi_inc >= (WI_W+1)'(WORDS)) begin
      adv_wi = '0;
      if (test_phase == PH_WALK) begin
        adv_wb = walk_bit + 6'd1;
        if (adv_wb == 6'd0) adv_ph = test_phase + 4'd1;
      end else begin
        adv_ph = test_phase + 4'd1;
      end
    end
  end

  // Pattern/address at the advanced position (same page).
  logic [63:0] adv_addr, adv_pat;
  always_comb begin
    adv_addr = mk_addr(cursor_page, adv_wi);
    if (full_m) begin
      if (adv_ph < PH_WALK) adv_pat = full_pattern(adv_ph[2:0]);
      else if (adv_ph == PH_WALK) adv_pat = 64'd1 << adv_wb;
      else adv_pat = adv_addr;
    end else if (test_mode == MODE_BASIC) begin
      adv_pat = (adv_ph == 4'd0) ? 64'h0 : 64'hFFFFFFFFFFFFFFFF;
    end else begin
      adv_pat = (adv_ph == 4'd0) ? 64'h5555555555555555 : 64'hAAAAAAAAAAAAAAAA;
    end
  end

  logic [35:0] pg_inc;
  logic [63:0] next_paddr;
  assign pg_inc = cursor_page + 36'd1;
  assign next_paddr = mk_addr(pg_inc, '0);

  always_comb begin
    run_active_next = run_active;
    cancel_flag_next = cancel_flag;
    cursor_page_next = cursor_page;
    test_phase_next = test_phase;
    walk_bit_next = walk_bit;
    word_index_next = word_index;
    error_counter_next = error_counter;
    awaiting_kind_next = awaiting_kind;
    r0 = '0;
    r1 = '0;
    e0 = 1'b0;
    e1 = 1'b0;
    if (fire) begin
      case (q_item.func)
        FUNC_START: begin
          run_active_next = 1'b1;
          cancel_flag_next = 1'b0;
          cursor_page_next = window_start_page;
          test_phase_next = '0;
          walk_bit_next = '0;
          word_index_next = '0;
          error_counter_next = '0;
          e0 = 1'b1;
          if (window_start_page >= window_end_page) begin
            run_active_next = 1'b0;
            awaiting_kind_next = WAIT_NONE;
            r0.kind = KIND_DONE;
          end else begin
            awaiting_kind_next = WAIT_PAGE;
            r0.kind = KIND_QUERY;
            r0.address = start_paddr[47:0];
          end
        end
        FUNC_CANCEL: begin
          if (run_active) cancel_flag_next = 1'b1;
        end
        default: begin
          if (run_active && ((q_item.func == FUNC_PAGE && awaiting_kind == WAIT_PAGE) ||
              (q_item.func == FUNC_RESP && (awaiting_kind == WAIT_WRITE ||
                                            awaiting_kind == WAIT_READ)))) begin
            logic do_pdone;
            logic do_adv;
            do_pdone = 1'b0;
            do_adv = 1'b0;
            if (cancel_flag) begin
              e0 = 1'b1;
              r0.kind = KIND_DONE;
              run_active_next = 1'b0;
              cancel_flag_next = 1'b0;
              awaiting_kind_next = WAIT_NONE;
            end else if (q_item.func == FUNC_PAGE) begin
              if (q_item.page_used) begin
                do_pdone = 1'b1;
              end else begin
                test_phase_next = '0;
                walk_bit_next = '0;
                word_index_next = '0;
                e0 = 1'b1;
                awaiting_kind_next = WAIT_WRITE;
                r0.kind = KIND_WRITE;
                r0.address = cur_paddr[47:0];
                r0.data = full_m ? 64'h0 : ((test_mode == MODE_BASIC) ? 64'h0 :
                                            64'h5555555555555555);
              end
            end else if (awaiting_kind == WAIT_WRITE) begin
              if (test_phase < ph_count && test_phase < PH_AWR) begin
                e0 = 1'b1;
                awaiting_kind_next = WAIT_READ;
                r0.kind = KIND_READ;
                r0.address = cur_waddr[47:0];
                r0.data = cur_pat;
              end else begin
                do_adv = 1'b1;
              end
            end else if (test_phase == PH_ARD) begin
              if (q_item.read_data != cur_waddr) begin
                if (error_counter != '1) error_counter_next = error_counter + 32'd1;
                if (error_counter < 32'(MAX_LOGGED_ERRORS)) begin
                  e0 = 1'b1;
                  r0.kind = KIND_ERROR;
                  r0.address = cur_paddr[47:0];
                  r0.error_total = error_counter_next;
                end
                do_pdone = 1'b1;
              end else begin
                do_adv = 1'b1;
              end
            end else if (test_phase == PH_WALK) begin
              do_adv = 1'b1;
            end else begin
              if (mismatch) begin
                if (error_counter != '1) error_counter_next = error_counter + 32'd1;
                if (error_counter < 32'(MAX_LOGGED_ERRORS)) begin
                  e0 = 1'b1;
                  r0.kind = KIND_ERROR;
                  r0.address = cur_waddr[47:0];
                  r0.data = cur_pat;
                  r0.actual = q_item.read_data;
                  r0.error_total = error_counter_next;
                end
              end
              do_adv = 1'b1;
            end
            if (do_adv) begin
              word_index_next = adv_wi;
              test_phase_next = adv_ph;
              walk_bit_next = adv_wb;
              if (adv_ph >= ph_count || WORDS == 0) begin
                do_pdone = 1'b1;
              end else begin
                e1 = 1'b1;
                awaiting_kind_next = (adv_ph == PH_ARD) ? WAIT_READ : WAIT_WRITE;
                r1.kind = (adv_ph == PH_ARD) ? KIND_READ : KIND_WRITE;
                r1.address = adv_addr[47:0];
                r1.data = adv_pat;
              end
            end
            if (do_pdone) begin
              cursor_page_next = pg_inc;
              e1 = 1'b1;
              if (pg_inc >= window_end_page) begin
                r1.kind = KIND_DONE;
                run_active_next = 1'b0;
                cancel_flag_next = 1'b0;
                awaiting_kind_next = WAIT_NONE;
              end else begin
                awaiting_kind_next = WAIT_PAGE;
                r1.kind = KIND_QUERY;
                r1.address = next_paddr[47:0];
              end
            end
          end
        end
      endcase
    end
    r0.error_total = error_counter_next;
    r1.error_total = error_counter_next;
    r0.last = !e1;
    r1.last = 1'b1;
    nres = {1'b0, e0} + {1'b0, e1};
  end

  logic pop;
  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (fire) begin
      if (e0 && e1) begin
        rb[0] <= r0;
        rb[1] <= r1;
      end else if (e0 || e1) begin
        rb[(rb_cnt == 2'd1 && !pop) ? ~rb_rd : (pop ? ~rb_rd : rb_rd)] <= e0 ? r0 : r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
      cancel_flag <= 1'b0;
      cursor_page <= '0;
      test_phase <= '0;
      walk_bit <= '0;
      word_index <= '0;
      error_counter <= '0;
      awaiting_kind <= WAIT_NONE;
      rb_rd <= 1'b0;
      rb_cnt <= 2'd0;
    end else begin
      run_active <= run_active_next;
      cancel_flag <= cancel_flag_next;
      cursor_page <= cursor_page_next;
      test_phase <= test_phase_next;
      walk_bit <= walk_bit_next;
      word_index <= word_index_next;
      error_counter <= error_counter_next;
      awaiting_kind <= awaiting_kind_next;
      if (fire && nres == 2'd2) rb_rd <= 1'b0;
      else if (pop) rb_rd <= ~rb_rd;
      rb_cnt <= rb_cnt + (fire ? nres : 2'd0) - {1'b0, pop};
    end
  end

  `ASSERT_CLK(a_rb_bound, clk, rst, rb_cnt <= 2'd2, "result buffer overflow")
  `ASSERT_CLK(a_idle_quiet, clk, rst, !run_active |-> awaiting_kind == WAIT_NONE, "outstanding command while idle")
  `ASSERT_CLK(a_two_fit, clk, rst, (fire && nres == 2'd2) |-> (rb_cnt == 2'd0 || pop), "two results into busy buffer")
endmodule
